// ===== hdl/itoad_pkg.sv =====
// ----------------------------------------------------------------------------
// itoad_pkg
// Shared types, constants and the digit-to-character function for the
// integer to ASCII digits core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoad_pkg;

  localparam int NUM_CELLS = 16;
  localparam int DIGIT_W   = 4;
  localparam int POS_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int ACTION_W  = 2;
  localparam int VALUE_W   = 64;

  // Format codes; any non-zero code selects hex, bit 1 selects upper case
  localparam logic [ACTION_W-1:0] ACT_DEC = 2'd0;

  // Control bundle broadcast to every digit cell
  typedef struct packed {
    logic clr;    // load zero into the cell
    logic shift;  // take the neighbor's bits this cycle
    logic dec;    // decimal (add-3 correction) instead of plain nibble shift
  } itoad_ctrl_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < 4'd10) begin
      base = 8'h30;
    end else if (upper) begin
      base = 8'h37;
    end else begin
      base = 8'h57;
    end
    return base + {4'h0, d};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_to_ascii_digits_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core
// An accepted item is shifted through the digit cell chain, then a length
// state finds the digit count. The chain takes 2 bits per cycle in decimal
// and 4 in hex. A new item is taken only after the last character is issued;
// characters come out one per cycle while out_ready does not hold them back.
// Reset (rst_n low, synchronous) returns to idle and drops any pending item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_digits_core #(
  parameter int HEX_VALUE_WIDTH = 64,
  parameter int DEC_VALUE_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [itoad_pkg::ACTION_W-1:0]       in_action,
  input  wire logic [itoad_pkg::VALUE_W-1:0]        in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [itoad_pkg::CHAR_W-1:0]         out_ascii_char,
  output logic      [itoad_pkg::POS_W-1:0]          out_position,
  output logic                                      out_last
);

  localparam int HW4       = ((HEX_VALUE_WIDTH + 3) / 4) * 4;
  localparam int DW2       = ((DEC_VALUE_WIDTH + 1) / 2) * 2;
  localparam int SR_W      = (HW4 > DW2) ? HW4 : DW2;
  localparam int HEX_STEPS = HW4 / 4;
  localparam int DEC_STEPS = DW2 / 2;
  localparam int MAX_STEPS = (HEX_STEPS > DEC_STEPS) ? HEX_STEPS : DEC_STEPS;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int CELL_IW   = $clog2(itoad_pkg::NUM_CELLS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                            state_r, state_nxt;
  logic [SR_W-1:0]                       sr_r, sr_nxt;
  logic [STEP_W-1:0]                     steps_r, steps_nxt;
  logic                                  dec_r, dec_nxt;
  logic                                  upper_r, upper_nxt;
  logic [itoad_pkg::POS_W-1:0]           left_r, left_nxt;
  logic [itoad_pkg::POS_W-1:0]           idx_r, idx_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [itoad_pkg::CHAR_W-1:0]          char_r, char_nxt;
  logic [itoad_pkg::POS_W-1:0]           pos_r, pos_nxt;
  logic                                  last_r, last_nxt;

  logic                                  in_fire;
  logic                                  in_is_dec;
  logic [SR_W-1:0]                       hex_load;
  logic [SR_W-1:0]                       dec_load;
  logic [itoad_pkg::DIGIT_W-1:0]         chain_in;
  logic [itoad_pkg::POS_W-1:0]           run_len;
  logic [CELL_IW-1:0]                    rd_idx;
  logic                                  out_free;
  itoad_pkg::itoad_ctrl_t                cell_ctrl;

  logic [itoad_pkg::DIGIT_W-1:0] cell_cin   [itoad_pkg::NUM_CELLS];
  logic [itoad_pkg::DIGIT_W-1:0] cell_cout  [itoad_pkg::NUM_CELLS];
  logic [itoad_pkg::DIGIT_W-1:0] cell_digit [itoad_pkg::NUM_CELLS];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_is_dec = (in_action == itoad_pkg::ACT_DEC);
  assign out_free  = !out_valid_r || out_ready;

  // Align the used value bits to the top of the shift register
  assign hex_load = SR_W'(in_value[HEX_VALUE_WIDTH-1:0]) << (SR_W - HW4);
  assign dec_load = SR_W'(in_value[DEC_VALUE_WIDTH-1:0]) << (SR_W - DW2);

  // Feed the bottom cell from the top of the shift register
  assign chain_in = dec_r ? {2'b00, sr_r[SR_W-1 -: 2]} : sr_r[SR_W-1 -: 4];

  always_comb begin
    cell_ctrl.clr   = in_fire;
    cell_ctrl.shift = (state_r == ST_CONV);
    cell_ctrl.dec   = dec_r;
  end

  // Build the digit chain, least significant digit in cell 0
  for (genvar i = 0; i < itoad_pkg::NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_cin[i] = chain_in;
    end else begin : g_rest
      assign cell_cin[i] = cell_cout[i-1];
    end
    itoad_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl),
      .cin   (cell_cin[i]),
      .cout  (cell_cout[i]),
      .digit (cell_digit[i])
    );
  end

  // Find the run length: highest non-zero cell, at least one digit
  always_comb begin
    run_len = itoad_pkg::POS_W'(1);
    for (int i = 0; i < itoad_pkg::NUM_CELLS; i++) begin
      if (cell_digit[i] != '0) begin
        run_len = itoad_pkg::POS_W'(i + 1);
      end
    end
  end

  assign rd_idx = CELL_IW'(left_r - itoad_pkg::POS_W'(1));

  // Sequence load, conversion, length and emission
  always_comb begin
    state_nxt     = state_r;
    sr_nxt        = sr_r;
    steps_nxt     = steps_r;
    dec_nxt       = dec_r;
    upper_nxt     = upper_r;
    left_nxt      = left_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;

    // Drop the held item once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          dec_nxt   = in_is_dec;
          upper_nxt = !in_is_dec && in_action[1];
          sr_nxt    = in_is_dec ? dec_load : hex_load;
          steps_nxt = in_is_dec ? STEP_W'(DEC_STEPS) : STEP_W'(HEX_STEPS);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        sr_nxt    = dec_r ? (sr_r << 2) : (sr_r << 4);
        steps_nxt = steps_r - STEP_W'(1);
        if (steps_r == STEP_W'(1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        left_nxt  = run_len;
        idx_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = itoad_pkg::digit_char(cell_digit[rd_idx], upper_r);
          pos_nxt       = idx_r + itoad_pkg::POS_W'(1);
          last_nxt      = (left_r == itoad_pkg::POS_W'(1));
          left_nxt      = left_r - itoad_pkg::POS_W'(1);
          idx_nxt       = idx_r + itoad_pkg::POS_W'(1);
          if (left_r == itoad_pkg::POS_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dec_r       <= 1'b0;
      upper_r     <= 1'b0;
      left_r      <= '0;
      idx_r       <= '0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dec_r       <= dec_nxt;
      upper_r     <= upper_nxt;
      left_r      <= left_nxt;
      idx_r       <= idx_nxt;
      steps_r     <= steps_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    sr_r   <= sr_nxt;
    char_r <= char_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = char_r;
  assign out_position   = pos_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// ===== hdl/itoad_cell.sv =====
// ----------------------------------------------------------------------------
// itoad_cell
// One digit cell of the conversion chain. In decimal mode it performs two
// shift-and-add-3 steps per cycle while ctrl.shift is set; in hex mode it takes
// its lower neighbor's whole nibble.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoad_cell (
  input  wire logic                          clk,
  input  wire itoad_pkg::itoad_ctrl_t        ctrl,
  input  wire logic [itoad_pkg::DIGIT_W-1:0] cin,
  output logic      [itoad_pkg::DIGIT_W-1:0] cout,
  output logic      [itoad_pkg::DIGIT_W-1:0] digit
);

  logic [itoad_pkg::DIGIT_W-1:0] digit_r;
  logic [itoad_pkg::DIGIT_W-1:0] digit_nxt;
  logic [itoad_pkg::DIGIT_W-1:0] step1_corr;
  logic [itoad_pkg::DIGIT_W-1:0] step1_digit;
  logic [itoad_pkg::DIGIT_W-1:0] step2_corr;
  logic [itoad_pkg::DIGIT_W-1:0] dec_digit;
  logic [itoad_pkg::DIGIT_W-1:0] dec_out;

  // Add 3 to a BCD digit of five or more before it is doubled
  function automatic logic [itoad_pkg::DIGIT_W-1:0] dabble(
      input logic [itoad_pkg::DIGIT_W-1:0] x);
    return (x >= 4'd5) ? x + 4'd3 : x;
  endfunction

  // Two dabble steps: cin[1] enters first, cin[0] second
  always_comb begin
    step1_corr  = dabble(digit_r);
    step1_digit = {step1_corr[2:0], cin[1]};
    step2_corr  = dabble(step1_digit);
    dec_digit   = {step2_corr[2:0], cin[0]};
    dec_out     = {2'b00, step1_corr[3], step2_corr[3]};
  end

  // Select next digit
  always_comb begin
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = ctrl.dec ? dec_digit : cin;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign cout  = ctrl.dec ? dec_out : digit_r;
  assign digit = digit_r;

endmodule

`default_nettype wire
